@@ design/sine_pwm_inverter_controller_top_macros.svh @@
// Assertion macros for the sine PWM inverter controller.
// Used by the top level only; empty bodies for synthesis.
`ifndef SINE_PWM_INVERTER_CONTROLLER_TOP_MACROS_SVH
`define SINE_PWM_INVERTER_CONTROLLER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define SPI_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define SPI_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define SPI_ASSERT(label, clk, rst_n, prop)
`define SPI_ASSERT_RST(label, clk, prop)
`endif
`endif

@@ design/spi_pkg.sv @@
// Package for the sine PWM inverter controller: types, constants, sine table.
// No dependencies.
`default_nettype none
package spi_pkg;
  localparam int PWM_CENTER = 1024;
  localparam logic [15:0] RAMP_MASK = 16'd255;
  localparam logic [15:0] RECOVER_MASK = 16'd15;
  localparam int SINE_TABLE_SIZE = 512;
  localparam int TAB_AW = $clog2(SINE_TABLE_SIZE);
  localparam int QTR = SINE_TABLE_SIZE / 4;
  localparam logic [15:0] LOW_SUPPLY_MV = 16'd1000;
  localparam int DIV_STEPS = 48;

  // reciprocals of the Taylor denominators (2n)(2n+1), scaled by 2^72
  localparam logic [127:0] TAYLOR_RECIP [9] = '{
    (128'd1 << 72) / 128'd6 + 128'd1,
    (128'd1 << 72) / 128'd20 + 128'd1,
    (128'd1 << 72) / 128'd42 + 128'd1,
    (128'd1 << 72) / 128'd72 + 128'd1,
    (128'd1 << 72) / 128'd110 + 128'd1,
    (128'd1 << 72) / 128'd156 + 128'd1,
    (128'd1 << 72) / 128'd210 + 128'd1,
    (128'd1 << 72) / 128'd272 + 128'd1,
    (128'd1 << 72) / 128'd342 + 128'd1
  };

  typedef enum logic [1:0] {
    CMD_FAST = 2'd0, CMD_SLOW = 2'd1, CMD_PEAK = 2'd2, CMD_RESTART = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    CFG_PHASE_STEP = 3'd0, CFG_TRIP = 3'd1, CFG_DEBOUNCE = 3'd2, CFG_BLANK = 3'd3,
    CFG_TEMP_LIMIT = 3'd4, CFG_TEMP_CLEAR = 3'd5, CFG_AMP_LIMIT = 3'd6, CFG_REG_K = 3'd7
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_INTERP, ST_SCALE, ST_DIV, ST_DONE
  } state_t;

  typedef struct packed {
    logic load;    // latch request, do scalar updates
    logic interp;  // capture interpolated sine
    logic scale;   // compute deviation
    logic div_start;
    logic div_step;
    logic div_end;
    logic finish;  // load output register
  } ctrl_t;

  typedef struct packed {
    logic is_fast_run;  // fast sample not faulted after update
    logic needs_div;
    logic div_last;
  } stat_t;

  // Q31 sine by quadrant symmetry and Taylor series; constant evaluation only
  function automatic logic signed [31:0] sine_of_phase(input logic [31:0] u);
    logic [1:0] quad;
    logic [63:0] r, x, x2, term, t;
    logic [127:0] prod;
    logic signed [63:0] sum;
    quad = u[31:30];
    r = {34'd0, u[29:0]};
    if (quad[0]) r = 64'h4000_0000 - r;
    x = (r * 64'd1686629713) >> 30;
    x2 = (x * x) >> 30;
    term = x;
    sum = $signed(x);
    for (int n = 1; n <= 9; n++) begin
      t = (term * x2) >> 30;
      prod = 128'(t) * TAYLOR_RECIP[n - 1];
      term = 64'(prod >> 72);
      sum = n[0] ? sum - $signed(term) : sum + $signed(term);
    end
    if (sum < 0) sum = 0;
    sum = sum * 2;
    if (sum > 64'sh7FFF_FFFF) sum = 64'sh7FFF_FFFF;
    return quad[1] ? -sum[31:0] : sum[31:0];
  endfunction

  function automatic logic [QTR:0][31:0] build_quarter();
    logic [QTR:0][31:0] q;
    for (int j = 0; j <= QTR; j++) q[j] = sine_of_phase(32'(j) << (32 - TAB_AW));
    return q;
  endfunction

  // first quadrant of the table, both ends included
  localparam logic [QTR:0][31:0] SINE_QTR = build_quarter();

  function automatic logic signed [31:0] sine_entry(input logic [TAB_AW-1:0] k);
    logic [TAB_AW-3:0] j;
    logic [TAB_AW-2:0] jj;
    logic signed [31:0] v;
    j = k[TAB_AW-3:0];
    jj = k[TAB_AW-2] ? (TAB_AW-1)'(QTR) - {1'b0, j} : {1'b0, j};
    v = SINE_QTR[jj];
    return k[TAB_AW-1] ? -v : v;
  endfunction
endpackage
`default_nettype wire

@@ design/spi_stream_if.sv @@
// Valid/ready stream interfaces for request and result channels.
// No dependencies.
`default_nettype none
interface spi_in_if (input wire logic clk);
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic signed [15:0] phase_current_a;
  logic signed [15:0] phase_current_b;
  logic [15:0] supply_mv;
  logic signed [15:0] temperature;
  modport source (output valid, command, phase_current_a, phase_current_b, supply_mv,
                  temperature, input ready);
  modport sink (input valid, command, phase_current_a, phase_current_b, supply_mv,
                temperature, output ready);
endinterface

interface spi_out_if (input wire logic clk);
  logic        valid;
  logic        ready;
  logic [15:0] duty_a;
  logic [15:0] duty_b;
  logic        output_enable;
  logic        fault_latched;
  logic        thermal_hold_active;
  logic [14:0] amplitude;
  logic [15:0] peak_current;
  modport source (output valid, duty_a, duty_b, output_enable, fault_latched,
                  thermal_hold_active, amplitude, peak_current, input ready);
  modport sink (input valid, duty_a, duty_b, output_enable, fault_latched,
                thermal_hold_active, amplitude, peak_current, output ready);
endinterface
`default_nettype wire

@@ design/spi_ctrl.sv @@
// Sequencer for the sine PWM inverter controller.
// Depends on spi_pkg.
`default_nettype none
module spi_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic          out_free,
  input  wire spi_pkg::stat_t stat,
  output spi_pkg::ctrl_t     ctrl
);
  import spi_pkg::*;
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    ctrl = '0;
    in_ready = (state_r == ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          ctrl.load = 1'b1;
          state_nxt = ST_INTERP;
        end
      end
      ST_INTERP: begin
        ctrl.interp = 1'b1;
        state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        ctrl.scale = 1'b1;
        if (stat.needs_div) begin
          ctrl.div_start = 1'b1;
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DIV: begin
        ctrl.div_step = 1'b1;
        if (stat.div_last) begin
          ctrl.div_end = 1'b1;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          ctrl.finish = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

@@ design/spi_datapath.sv @@
// Datapath: protection, slew, DDS with interpolated sine, serial divider.
// Depends on spi_pkg.
`default_nettype none
module spi_datapath (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cfg_we,
  input  wire logic [2:0]     cfg_idx,
  input  wire logic [47:0]    cfg_data,
  input  wire logic [1:0]     in_cmd,
  input  wire logic signed [15:0] in_ia,
  input  wire logic signed [15:0] in_ib,
  input  wire logic [15:0]    in_mv,
  input  wire logic signed [15:0] in_temp,
  input  wire spi_pkg::ctrl_t ctrl,
  output spi_pkg::stat_t      stat,
  output logic [15:0]         res_duty_a,
  output logic [15:0]         res_duty_b,
  output logic                res_fault,
  output logic                res_thermal,
  output logic [14:0]         res_amp,
  output logic [15:0]         res_peak
);
  import spi_pkg::*;

  logic [31:0] phase_step_r, blank_cfg_r;
  logic [15:0] trip_r, debounce_r;
  logic signed [15:0] tlim_r, tclr_r;
  logic [14:0] amp_limit_r;
  logic [47:0] regk_r;

  logic [31:0] phase_r, blank_r;
  logic [14:0] amp_r, target_r;
  logic [15:0] presc_r, run_r, peak_r, peak_out_r;
  logic fault_r, thermal_r, ramp_r;
  logic fast_run_r, needs_div_r;
  logic [15:0] mv_r;

  logic signed [31:0] sine_a_r, sine_b_r, s_r;
  logic [31:0] frac_r;
  logic signed [15:0] dev_r;
  logic [47:0] quo_r, rem_r;
  logic [5:0] cnt_r;
  logic [48:0] trial;
  logic [47:0] quo_fin;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r <= '0; trip_r <= 16'd32768; debounce_r <= 16'd4;
      blank_cfg_r <= '0; tlim_r <= 16'sh7FFF; tclr_r <= 16'sh8000;
      amp_limit_r <= '0; regk_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_idx))
        CFG_PHASE_STEP: phase_step_r <= cfg_data[31:0];
        CFG_TRIP:       trip_r <= cfg_data[15:0];
        CFG_DEBOUNCE:   debounce_r <= cfg_data[15:0];
        CFG_BLANK:      blank_cfg_r <= cfg_data[31:0];
        CFG_TEMP_LIMIT: tlim_r <= cfg_data[15:0];
        CFG_TEMP_CLEAR: tclr_r <= cfg_data[15:0];
        CFG_AMP_LIMIT:  amp_limit_r <= cfg_data[14:0];
        CFG_REG_K:      regk_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // scalar updates of the accepted request
  logic [15:0] ma, mb, imax, run_n, presc_n, mask;
  logic [14:0] tgt, amp_n;
  logic [31:0] blank_n;
  logic fault_n, ramp_n, thermal_n;
  always_comb begin
    ma = in_ia[15] ? 16'(-in_ia) : in_ia;
    mb = in_ib[15] ? 16'(-in_ib) : in_ib;
    imax = (ma > mb) ? ma : mb;
    blank_n = (blank_r != 0) ? blank_r - 32'd1 : blank_r;
    run_n = run_r;
    fault_n = fault_r;
    if (blank_n == 0 && imax > trip_r) begin
      if (run_r != 16'hFFFF) run_n = run_r + 16'd1;
      if (run_n >= debounce_r) fault_n = 1'b1;
    end else begin
      run_n = '0;
    end
    tgt = thermal_r ? '0 : target_r;
    mask = ramp_r ? RECOVER_MASK : RAMP_MASK;
    presc_n = presc_r + 16'd1;
    amp_n = amp_r;
    if ((presc_n & mask) == 0) begin
      if (amp_r < tgt) amp_n = amp_r + 15'd1;
      else if (amp_r > tgt) amp_n = amp_r - 15'd1;
    end
    ramp_n = ramp_r | ((tgt != 0) && (amp_n >= tgt));
    thermal_n = thermal_r;
    if (in_temp > tlim_r) thermal_n = 1'b1;
    else if (in_temp < tclr_r) thermal_n = 1'b0;
  end

  logic [TAB_AW-1:0] idx, idx_b;
  logic [31:0] ph_n;
  assign ph_n = phase_r + phase_step_r;
  assign idx = ph_n[31 -: TAB_AW];
  assign idx_b = idx + TAB_AW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0; amp_r <= '0; target_r <= '0; presc_r <= '0; fault_r <= 1'b0;
      thermal_r <= 1'b0; run_r <= '0; blank_r <= '0; peak_r <= '0; ramp_r <= 1'b0;
      fast_run_r <= 1'b0; needs_div_r <= 1'b0;
    end else if (ctrl.load) begin
      mv_r <= in_mv;
      peak_out_r <= peak_r;
      fast_run_r <= 1'b0;
      needs_div_r <= 1'b0;
      unique case (cmd_t'(in_cmd))
        CMD_FAST: begin
          if (imax > peak_r) begin
            peak_r <= imax; peak_out_r <= imax;
          end
          blank_r <= blank_n; run_r <= run_n; fault_r <= fault_n;
          if (!fault_n) begin
            presc_r <= presc_n; amp_r <= amp_n; ramp_r <= ramp_n;
            phase_r <= ph_n; fast_run_r <= 1'b1;
            sine_a_r <= sine_entry(idx);
            sine_b_r <= sine_entry(idx_b);
            frac_r <= {ph_n[31-TAB_AW:0], TAB_AW'(0)};
          end
        end
        CMD_SLOW: begin
          thermal_r <= thermal_n;
          if (!fault_r) begin
            if (regk_r == 0) target_r <= amp_limit_r;
            else if (in_mv < LOW_SUPPLY_MV) target_r <= '0;
            else needs_div_r <= 1'b1;
          end
        end
        CMD_PEAK: peak_r <= '0;
        CMD_RESTART: begin
          phase_r <= '0; amp_r <= '0; target_r <= '0; presc_r <= '0; fault_r <= 1'b0;
          thermal_r <= 1'b0; run_r <= '0; blank_r <= blank_cfg_r; peak_r <= '0;
          ramp_r <= 1'b0; peak_out_r <= '0;
        end
        default: ;
      endcase
    end else if (ctrl.div_end) begin
      target_r <= (quo_fin > 48'(amp_limit_r)) ? amp_limit_r : quo_fin[14:0];
    end
  end

  // interpolation: a + floor((b-a)*frac / 2^32)
  logic signed [32:0] d;
  logic signed [65:0] prod;
  logic signed [33:0] s_full;
  assign d = 33'(sine_b_r) - 33'(sine_a_r);
  assign prod = d * $signed({1'b0, frac_r});
  assign s_full = 34'(sine_a_r) + 34'(prod >>> 32);
  logic signed [47:0] dprod;
  assign dprod = s_r * $signed({1'b0, amp_r});

  always_ff @(posedge clk) begin
    if (ctrl.interp) begin
      if (s_full > 34'sh7FFF_FFFF) s_r <= 32'sh7FFF_FFFF;
      else if (s_full < -34'sh8000_0000) s_r <= 32'sh8000_0000;
      else s_r <= s_full[31:0];
    end
    if (ctrl.scale) dev_r <= 16'(dprod >>> 31);
  end

  // restoring divider, one quotient bit per cycle
  assign trial = {rem_r, quo_r[47]} - {33'd0, mv_r};
  assign quo_fin = {quo_r[46:0], !trial[48]};
  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else if (ctrl.div_start) begin
      rem_r <= '0; quo_r <= regk_r; cnt_r <= 6'(DIV_STEPS - 1);
    end else if (ctrl.div_step) begin
      if (!trial[48]) begin
        rem_r <= trial[47:0]; quo_r <= {quo_r[46:0], 1'b1};
      end else begin
        rem_r <= {rem_r[46:0], quo_r[47]}; quo_r <= {quo_r[46:0], 1'b0};
      end
      cnt_r <= cnt_r - 6'd1;
    end
  end

  assign stat.is_fast_run = fast_run_r;
  assign stat.needs_div = needs_div_r;
  assign stat.div_last = (cnt_r == 0);

  assign res_duty_a = fast_run_r ? 16'(PWM_CENTER) + dev_r : 16'(PWM_CENTER);
  assign res_duty_b = fast_run_r ? 16'(PWM_CENTER) - dev_r : 16'(PWM_CENTER);
  assign res_fault = fault_r;
  assign res_thermal = thermal_r;
  assign res_amp = amp_r;
  assign res_peak = peak_out_r;
endmodule
`default_nettype wire

@@ design/sine_pwm_inverter_controller_top.sv @@
// Sine PWM inverter controller, top level.
// A request is loaded in idle, then passes interp, scale, the bit-serial 48-step
// divider (regulated slow update only) and done, where the result is registered.
// Requests are handled one at a time; a stalled result holds the sequencer.
// Reset: synchronous active-low rst_n restores state and control registers, not data.
`default_nettype none
`include "sine_pwm_inverter_controller_top_macros.svh"
module sine_pwm_inverter_controller_top (
  input  wire logic  clk,
  input  wire logic  rst_n,
  spi_in_if.sink     in_ch,
  spi_out_if.source  out_ch,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_idx,
  input  wire logic [47:0] cfg_data
);
  import spi_pkg::*;
  ctrl_t ctrl;
  stat_t stat;
  logic out_valid_r;
  logic [15:0] da, db, pk;
  logic fl, th;
  logic [14:0] am;

  spi_ctrl u_ctrl (
    .clk, .rst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_free(!out_valid_r || out_ch.ready), .stat, .ctrl
  );

  spi_datapath u_dp (
    .clk, .rst_n, .cfg_we, .cfg_idx, .cfg_data,
    .in_cmd(in_ch.command), .in_ia(in_ch.phase_current_a), .in_ib(in_ch.phase_current_b),
    .in_mv(in_ch.supply_mv), .in_temp(in_ch.temperature), .ctrl, .stat,
    .res_duty_a(da), .res_duty_b(db), .res_fault(fl), .res_thermal(th),
    .res_amp(am), .res_peak(pk)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (ctrl.finish) out_valid_r <= 1'b1;
    else if (out_ch.ready) out_valid_r <= 1'b0;
    if (ctrl.finish) begin
      out_ch.duty_a <= da; out_ch.duty_b <= db; out_ch.output_enable <= !fl;
      out_ch.fault_latched <= fl; out_ch.thermal_hold_active <= th;
      out_ch.amplitude <= am; out_ch.peak_current <= pk;
    end
  end
  assign out_ch.valid = out_valid_r;

  `SPI_ASSERT(a_finish_free, clk, rst_n, ctrl.finish |-> (!out_valid_r || out_ch.ready))
  `SPI_ASSERT(a_no_accept_busy, clk, rst_n, ctrl.div_step |-> !in_ch.ready)
  `SPI_ASSERT(a_oe, clk, rst_n, out_valid_r |-> (out_ch.output_enable != out_ch.fault_latched))
  `SPI_ASSERT_RST(a_rst, clk, !rst_n |=> !out_valid_r)
endmodule
`default_nettype wire

@@ sim/tb_sine_pwm_inverter_controller_top.sv @@
// Testbench for sine_pwm_inverter_controller_top: random and directed requests
// checked against a behavioural predictor of the controller. Depends on spi_pkg,
// spi_in_if / spi_out_if and the design top level.
`timescale 1ns / 1ps
module tb_sine_pwm_inverter_controller_top;
  import spi_pkg::*;

  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 64;

  typedef struct packed {
    logic [15:0] duty_a;
    logic [15:0] duty_b;
    logic        output_enable;
    logic        fault_latched;
    logic        thermal_hold_active;
    logic [14:0] amplitude;
    logic [15:0] peak_current;
  } pwm_result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [2:0] cfg_idx;
  logic [47:0] cfg_data;

  spi_in_if in_ch (clk);
  spi_out_if out_ch (clk);

  sine_pwm_inverter_controller_top dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  // settings and state of the predicted controller
  logic [31:0] k_phase_step, k_blank;
  logic [15:0] k_trip, k_debounce;
  logic signed [15:0] k_temp_limit, k_temp_clear;
  logic [14:0] k_amp_limit;
  logic [47:0] k_reg_const;
  logic [31:0] p_phase, p_blank;
  logic [14:0] p_amp, p_target;
  logic [15:0] p_prescale, p_oc_run, p_peak;
  logic p_fault, p_thermal, p_ramp_done;

  logic signed [31:0] sine_lut [0:SINE_TABLE_SIZE];
  pwm_result_t expected_pwm_q[$];
  int fails;
  bit quiet;
  int stall_left;
  int idle_cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic signed [31:0] taylor_sine(input logic [31:0] ph);
    logic [63:0] r, x, x2, term;
    longint acc;
    r = {34'd0, ph[29:0]};
    if (ph[30]) r = 64'h4000_0000 - r;
    x = (r * 64'd1686629713) >> 30;
    x2 = (x * x) >> 30;
    term = x;
    acc = longint'(x);
    for (int n = 1; n <= 9; n++) begin
      term = ((term * x2) >> 30) / (64'(2 * n) * 64'(2 * n + 1));
      acc = (n % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
    end
    if (acc < 0) acc = 0;
    acc = acc * 2;
    if (acc > 64'sh7FFF_FFFF) acc = 64'sh7FFF_FFFF;
    return ph[31] ? -acc[31:0] : acc[31:0];
  endfunction

  function automatic longint interpolated_sine(input logic [31:0] ph);
    int idx;
    longint base, delta, frac, s;
    idx = ph[31:23];
    frac = longint'({ph[22:0], 9'd0});
    base = sine_lut[idx];
    delta = longint'(sine_lut[idx + 1]) - base;
    s = base + ((delta * frac) >>> 32);
    if (s > 64'sh7FFF_FFFF) s = 64'sh7FFF_FFFF;
    if (s < -64'sh8000_0000) s = -64'sh8000_0000;
    return s;
  endfunction

  task automatic restart_controller();
    p_phase = 0; p_amp = 0; p_target = 0; p_prescale = 0;
    p_fault = 0; p_thermal = 0; p_oc_run = 0; p_blank = k_blank;
    p_peak = 0; p_ramp_done = 0;
  endtask

  task automatic predict_pwm(input cmd_t cmd, input logic signed [15:0] ia,
                             input logic signed [15:0] ib, input logic [15:0] mv,
                             input logic signed [15:0] temp_c);
    pwm_result_t res;
    int ma, mb, imax;
    logic [14:0] tgt;
    logic [15:0] mask;
    longint dev;
    logic [63:0] quot;
    res.duty_a = 16'(PWM_CENTER);
    res.duty_b = 16'(PWM_CENTER);
    case (cmd)
      CMD_FAST: begin
        ma = ia < 0 ? -int'(ia) : int'(ia);
        mb = ib < 0 ? -int'(ib) : int'(ib);
        imax = ma > mb ? ma : mb;
        if (imax > int'(p_peak)) p_peak = 16'(imax);
        if (p_blank != 0) p_blank--;
        if (p_blank == 0 && imax > int'(k_trip)) begin
          if (p_oc_run != 16'hFFFF) p_oc_run++;
          if (p_oc_run >= k_debounce) p_fault = 1;
        end else begin
          p_oc_run = 0;
        end
        if (!p_fault) begin
          tgt = p_thermal ? 15'd0 : p_target;
          mask = p_ramp_done ? RECOVER_MASK : RAMP_MASK;
          p_prescale = p_prescale + 16'd1;
          if ((p_prescale & mask) == 0) begin
            if (p_amp < tgt) p_amp++;
            else if (p_amp > tgt) p_amp--;
          end
          if (tgt > 0 && p_amp >= tgt) p_ramp_done = 1;
          p_phase = p_phase + k_phase_step;
          dev = (interpolated_sine(p_phase) * longint'(p_amp)) >>> 31;
          res.duty_a = 16'(longint'(PWM_CENTER) + dev);
          res.duty_b = 16'(longint'(PWM_CENTER) - dev);
        end
        res.peak_current = p_peak;
      end
      CMD_SLOW: begin
        if (temp_c > k_temp_limit) p_thermal = 1;
        else if (temp_c < k_temp_clear) p_thermal = 0;
        if (!p_fault) begin
          if (k_reg_const == 0) p_target = k_amp_limit;
          else if (mv < LOW_SUPPLY_MV) p_target = 0;
          else begin
            quot = {16'd0, k_reg_const} / {48'd0, mv};
            p_target = quot > {49'd0, k_amp_limit} ? k_amp_limit : quot[14:0];
          end
        end
        res.peak_current = p_peak;
      end
      CMD_PEAK: begin
        res.peak_current = p_peak;
        p_peak = 0;
      end
      default: begin
        restart_controller();
        res.peak_current = p_peak;
      end
    endcase
    res.output_enable = !p_fault;
    res.fault_latched = p_fault;
    res.thermal_hold_active = p_thermal;
    res.amplitude = p_amp;
    expected_pwm_q.push_back(res);
  endtask

  task automatic send_request(input cmd_t cmd, input logic signed [15:0] ia,
                              input logic signed [15:0] ib, input logic [15:0] mv,
                              input logic signed [15:0] temp_c);
    int gap;
    gap = (!quiet && $urandom_range(0, 5) == 0) ? $urandom_range(1, 18) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= cmd;
    in_ch.phase_current_a <= ia;
    in_ch.phase_current_b <= ib;
    in_ch.supply_mv <= mv;
    in_ch.temperature <= temp_c;
    do @(posedge clk); while (!in_ch.ready);
    predict_pwm(cmd, ia, ib, mv, temp_c);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [47:0] value);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      CFG_PHASE_STEP: k_phase_step = value[31:0];
      CFG_TRIP:       k_trip = value[15:0];
      CFG_DEBOUNCE:   k_debounce = value[15:0];
      CFG_BLANK:      k_blank = value[31:0];
      CFG_TEMP_LIMIT: k_temp_limit = value[15:0];
      CFG_TEMP_CLEAR: k_temp_clear = value[15:0];
      CFG_AMP_LIMIT:  k_amp_limit = value[14:0];
      default:        k_reg_const = value;
    endcase
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    cfg_we <= 1'b0;
    @(posedge clk);
    while (expected_pwm_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_random(input int n_items, input bit with_restart);
    cmd_t cmd;
    int pick;
    logic signed [15:0] ia, ib;
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) cmd = CMD_FAST;
      else if (pick < 90) cmd = CMD_SLOW;
      else if (pick < 96 || !with_restart) cmd = CMD_PEAK;
      else cmd = CMD_RESTART;
      ia = 16'($urandom);
      ib = 16'($urandom);
      if ($urandom_range(0, 3) == 0) ia = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7FFF;
      else if ($urandom_range(0, 1) == 0)
        ia = $signed(16'($urandom_range(0, 600))) - 16'sd300;
      send_request(cmd, ia, ib, 16'($urandom), 16'($urandom));
    end
  endtask

  task automatic test_defaults();
    send_request(CMD_FAST, 16'sh8000, 16'sh7FFF, 16'd0, 16'sd0);
    send_request(CMD_FAST, 16'sd0, 16'sd0, 16'hFFFF, 16'sd0);
    send_request(CMD_PEAK, 16'sd0, 16'sd0, 16'd0, 16'sd0);
    send_request(CMD_SLOW, 16'sd0, 16'sd0, 16'd0, 16'sh7FFF);
    send_request(CMD_RESTART, 16'sd0, 16'sd0, 16'd0, 16'sd0);
    drain();
  endtask

  task automatic test_overcurrent();
    write_reg(CFG_BLANK, 48'd2);
    write_reg(CFG_TRIP, 48'd100);
    write_reg(CFG_DEBOUNCE, 48'd2);
    write_reg(CFG_TEMP_LIMIT, 48'd30);
    write_reg(CFG_TEMP_CLEAR, 48'd20);
    drain();
    send_request(CMD_RESTART, 16'sd0, 16'sd0, 16'd0, 16'sd0);
    repeat (4) send_request(CMD_FAST, 16'sd200, -16'sd101, 16'd0, 16'sd0);
    send_request(CMD_SLOW, 16'sd0, 16'sd0, 16'd5000, 16'sd40);
    send_request(CMD_RESTART, 16'sd0, 16'sd0, 16'd0, 16'sd0);
    drain();
    write_reg(CFG_DEBOUNCE, 48'd0);
    write_reg(CFG_BLANK, 48'd0);
    drain();
    send_request(CMD_RESTART, 16'sd0, 16'sd0, 16'd0, 16'sd0);
    send_request(CMD_FAST, 16'sd0, -16'sd101, 16'd0, 16'sd0);
    send_request(CMD_RESTART, 16'sd0, 16'sd0, 16'd0, 16'sd0);
    drain();
  endtask

  task automatic test_regulation();
    write_reg(CFG_REG_K, 48'hFFFF_FFFF_FFFF);
    write_reg(CFG_AMP_LIMIT, 48'h7FFF);
    write_reg(CFG_TEMP_LIMIT, 48'hFFFF_8000);
    write_reg(CFG_TEMP_CLEAR, 48'h7FFF);
    drain();
    send_request(CMD_SLOW, 16'sd0, 16'sd0, 16'd999, 16'sh8000);
    send_request(CMD_SLOW, 16'sd0, 16'sd0, 16'd1000, -16'sd1);
    send_request(CMD_SLOW, 16'sd0, 16'sd0, 16'hFFFF, 16'sh7FFF);
    drain();
    write_reg(CFG_REG_K, 48'd5000000);
    drain();
    send_request(CMD_SLOW, 16'sd0, 16'sd0, 16'd1000, 16'sd0);
    send_request(CMD_SLOW, 16'sd0, 16'sd0, 16'd0, 16'sd0);
    drain();
  endtask

  task automatic test_ramp_and_sine();
    write_reg(CFG_REG_K, 48'd0);
    write_reg(CFG_AMP_LIMIT, 48'd1);
    write_reg(CFG_TRIP, 48'd32768);
    write_reg(CFG_TEMP_LIMIT, 48'h7FFF);
    write_reg(CFG_TEMP_CLEAR, 48'hFFFF_8000);
    write_reg(CFG_PHASE_STEP, 48'($urandom));
    drain();
    send_request(CMD_RESTART, 16'sd0, 16'sd0, 16'd0, 16'sd0);
    send_request(CMD_SLOW, 16'sd0, 16'sd0, 16'd0, 16'sd0);
    send_random(270, 1'b0);
    drain();
  endtask

  task automatic test_random_mix();
    write_reg(CFG_AMP_LIMIT, 48'h7FFF);
    write_reg(CFG_PHASE_STEP, 48'hFFFF_FFFF);
    write_reg(CFG_DEBOUNCE, 48'hFFFF);
    write_reg(CFG_BLANK, 48'hFFFF_FFFF);
    drain();
    send_request(CMD_SLOW, 16'sd0, 16'sd0, 16'd0, 16'sd0);
    send_random(40, 1'b0);
    drain();
    write_reg(CFG_PHASE_STEP, 48'($urandom));
    write_reg(CFG_TRIP, 48'($urandom_range(0, 400)));
    write_reg(CFG_DEBOUNCE, 48'($urandom_range(1, 4)));
    write_reg(CFG_BLANK, 48'($urandom_range(0, 3)));
    write_reg(CFG_TEMP_LIMIT, 48'($urandom));
    write_reg(CFG_TEMP_CLEAR, 48'($urandom));
    write_reg(CFG_REG_K, {16'($urandom), 32'($urandom)});
    drain();
    send_random(60, 1'b1);
    quiet = 1;
    send_random(40, 1'b1);
    drain();
  endtask

  always @(posedge clk) begin
    logic rdy;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      rdy = 1'b1;
      if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 18) - 1;
        rdy = 1'b0;
      end
      out_ch.ready <= rdy;
    end
  end

  always @(posedge clk) begin
    pwm_result_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_pwm_q.size() == 0) begin
        $error("result with no request outstanding");
        fails++;
      end else begin
        exp_r = expected_pwm_q.pop_front();
        if (out_ch.duty_a !== exp_r.duty_a) begin
          $error("duty_a expected %0d actual %0d", exp_r.duty_a, out_ch.duty_a); fails++;
        end
        if (out_ch.duty_b !== exp_r.duty_b) begin
          $error("duty_b expected %0d actual %0d", exp_r.duty_b, out_ch.duty_b); fails++;
        end
        if (out_ch.output_enable !== exp_r.output_enable) begin
          $error("output_enable expected %0d actual %0d", exp_r.output_enable,
                 out_ch.output_enable); fails++;
        end
        if (out_ch.fault_latched !== exp_r.fault_latched) begin
          $error("fault_latched expected %0d actual %0d", exp_r.fault_latched,
                 out_ch.fault_latched); fails++;
        end
        if (out_ch.thermal_hold_active !== exp_r.thermal_hold_active) begin
          $error("thermal_hold_active expected %0d actual %0d", exp_r.thermal_hold_active,
                 out_ch.thermal_hold_active); fails++;
        end
        if (out_ch.amplitude !== exp_r.amplitude) begin
          $error("amplitude expected %0d actual %0d", exp_r.amplitude, out_ch.amplitude);
          fails++;
        end
        if (out_ch.peak_current !== exp_r.peak_current) begin
          $error("peak_current expected %0d actual %0d", exp_r.peak_current,
                 out_ch.peak_current); fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    fails = 0;
    quiet = 0;
    idle_cycles = 0;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_idx <= CFG_PHASE_STEP;
    cfg_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.command <= CMD_FAST;
    in_ch.phase_current_a <= '0;
    in_ch.phase_current_b <= '0;
    in_ch.supply_mv <= '0;
    in_ch.temperature <= '0;
    for (int k = 0; k < SINE_TABLE_SIZE; k++)
      sine_lut[k] = taylor_sine(32'((64'(k) << 32) / SINE_TABLE_SIZE));
    sine_lut[SINE_TABLE_SIZE] = sine_lut[0];
    k_phase_step = 0; k_trip = 16'd32768; k_debounce = 16'd4; k_blank = 0;
    k_temp_limit = 16'sh7FFF; k_temp_clear = 16'sh8000; k_amp_limit = 0; k_reg_const = 0;
    restart_controller();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_defaults();
    test_overcurrent();
    test_regulation();
    test_ramp_and_sine();
    test_random_mix();
    if (fails == 0 && expected_pwm_q.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end
endmodule
